// ===== rtl/histeq_pkg.sv =====
// Package: shared constants and types for the histogram equalizer.
`timescale 1ns / 1ps
package histeq_pkg;
  localparam int LEVELS = 256;
  localparam int MAX_PIXELS = 1048576;
  localparam int BIN_W = $clog2(LEVELS);
  localparam int CNT_W = 21;
  localparam int CUM_W = 29;   // LEVELS * MAX_PIXELS fits
  localparam int PROD_W = 37;  // 255 * cumulative
  localparam int PIX_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_RUN, ST_BUILD_RD, ST_BUILD_DIV, ST_BUILD_WR
  } state_t;

  typedef enum logic {OP_COUNT = 1'b0, OP_MAP = 1'b1} op_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [PIX_W-1:0] p);
    if (int'(p) >= LEVELS) return BIN_W'(LEVELS - 1);
    return BIN_W'(p);
  endfunction
endpackage

// ===== rtl/histogram_equalizer_top.sv =====
// Top level of the 8-bit histogram equalizer.
//
//   channel | signals                      | direction
//   input   | in_valid in_ready op pixel last | in
//   output  | out_valid out_ready pixel_out last_out | out
//
// In both passes an item is taken only once the previous one has left the
// pipe register (bin RAM read then write back). After a count item marked
// last, the table is built bin by bin (bin read, divide start, 37-step
// restoring divide, write). A map item marked last starts a clearing sweep
// of all 256 bins of the bin RAM; reset starts the same sweep. No item is
// taken during build or sweep. A stalled output holds off the next input item.
`timescale 1ns / 1ps
module histogram_equalizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [histeq_pkg::PIX_W-1:0]  pixel,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [histeq_pkg::PIX_W-1:0]  pixel_out,
  output logic                          last_out
);
  import histeq_pkg::*;

  histeq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pixel(pixel), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .pixel_out(pixel_out), .last_out(last_out)
  );
endmodule

// ===== rtl/histeq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/histeq_div.sv =====
// Restoring divider: quotient of product / total, saturated to 255, or 0 for a zero total.
`timescale 1ns / 1ps
module histeq_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [histeq_pkg::PROD_W-1:0]  dividend,
  input  logic [histeq_pkg::CNT_W-1:0]   divisor,
  output logic                           done,
  output logic [histeq_pkg::PIX_W-1:0]   quotient
);
  import histeq_pkg::*;
  localparam int STEP_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] num;
  logic [PROD_W-1:0] quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;

  assign shifted = {rem[CNT_W-1:0], num[PROD_W-1]};
  assign diff = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(PROD_W);
        num <= dividend;
        den <= divisor;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (!diff[CNT_W]) begin
          rem <= diff;
          quo <= {quo[PROD_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[PROD_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (den == '0) quotient = '0;
    else if (quo > PROD_W'(255)) quotient = 8'd255;
    else quotient = quo[PIX_W-1:0];
  end
endmodule

// ===== rtl/histeq_ctrl.sv =====
// Sequencer: pass control, histogram update, table build and clearing sweep.
`timescale 1ns / 1ps
module histeq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [histeq_pkg::PIX_W-1:0]  pixel,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [histeq_pkg::PIX_W-1:0]  pixel_out,
  output logic                          last_out
);
  import histeq_pkg::*;

  state_t state, state_next;
  logic [BIN_W-1:0] idx;          // sweep / build index
  logic [CNT_W-1:0] pixel_total;
  logic [CUM_W-1:0] cum;

  // pipeline register for accepted item (count read-modify-write / map read)
  logic             p_valid;
  logic             p_op;
  logic             p_last;
  logic [BIN_W-1:0] p_bin;

  logic             accept;
  logic             out_free;

  logic             bin_we;
  logic [BIN_W-1:0] bin_waddr, bin_raddr;
  logic [CNT_W-1:0] bin_wdata, bin_rdata;
  logic             map_we;
  logic [PIX_W-1:0] map_wdata, map_rdata;
  logic             div_start, div_done;
  logic [PIX_W-1:0] div_q;
  logic [CNT_W-1:0] inc_val;
  logic [CUM_W-1:0] cum_next;

  histeq_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_bins (
    .clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
    .raddr(bin_raddr), .rdata(bin_rdata)
  );

  histeq_ram #(.WIDTH(PIX_W), .DEPTH(LEVELS)) u_map (
    .clk(clk), .we(map_we), .waddr(idx), .wdata(map_wdata),
    .raddr(bin_raddr), .rdata(map_rdata)
  );

  histeq_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(PROD_W'(cum_next) * PROD_W'(255)),
    .divisor(pixel_total), .done(div_done), .quotient(div_q)
  );

  // output slot free next cycle for a map item in the pipe stage
  assign out_free = !out_valid || out_ready;
  // one item in flight at a time: simplest hazard-free read-modify-write
  assign in_ready = (state == ST_RUN) && !p_valid && out_free;
  assign accept = in_valid && in_ready;

  assign inc_val = (bin_rdata < CNT_MAX) ? bin_rdata + 1'b1 : bin_rdata;
  assign cum_next = cum + CUM_W'(bin_rdata);

  always_comb begin
    bin_raddr = accept ? bin_of(pixel) : idx;
    bin_we = 1'b0;
    bin_waddr = idx;
    bin_wdata = '0;
    map_we = 1'b0;
    map_wdata = div_q;
    div_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        bin_we = 1'b1;
      end
      ST_RUN: begin
        if (p_valid && p_op == OP_COUNT) begin
          bin_we = 1'b1;
          bin_waddr = p_bin;
          bin_wdata = inc_val;
        end
      end
      ST_BUILD_RD: ;
      ST_BUILD_DIV: div_start = 1'b1;
      ST_BUILD_WR: map_we = div_done;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (idx == BIN_W'(LEVELS - 1)) state_next = ST_RUN;
      ST_RUN: begin
        if (p_valid && p_last) begin
          if (p_op == OP_COUNT) state_next = ST_BUILD_RD;
          else state_next = ST_CLEAR;
        end
      end
      ST_BUILD_RD: state_next = ST_BUILD_DIV;
      ST_BUILD_DIV: state_next = ST_BUILD_WR;
      ST_BUILD_WR: begin
        if (div_done) begin
          if (idx == BIN_W'(LEVELS - 1)) state_next = ST_RUN;
          else state_next = ST_BUILD_RD;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx <= '0;
      p_valid <= 1'b0;
      out_valid <= 1'b0;
      pixel_total <= '0;
      cum <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      p_valid <= accept;
      if (accept) begin
        p_op <= op;
        p_last <= last;
        p_bin <= bin_of(pixel);
        if (op == OP_COUNT && pixel_total < CNT_MAX) pixel_total <= pixel_total + 1'b1;
      end
      if (p_valid && p_op == OP_MAP) begin
        out_valid <= 1'b1;
        pixel_out <= map_rdata;
        last_out <= p_last;
      end
      case (state)
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          pixel_total <= '0;
        end
        ST_RUN: begin
          idx <= '0;
          cum <= '0;
        end
        ST_BUILD_DIV: cum <= cum_next;
        ST_BUILD_WR: if (div_done) idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/histeq_checker.sv =====
// Port-level assertions for the histogram equalizer, bound to the top level.
`timescale 1ns / 1ps
module histeq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         op,
  input logic [histeq_pkg::PIX_W-1:0] pixel,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [histeq_pkg::PIX_W-1:0] pixel_out,
  input logic                         last_out
);
  import histeq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_out))
    else $error("output item changed while stalled");

  a_map_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_MAP |=> ##1 out_valid)
    else $error("map item gave no result");

  a_count_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_COUNT |=> ##1 !out_valid)
    else $error("count item gave a result");

  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("accepted item right after a last item");
endmodule

bind histogram_equalizer_top histeq_checker u_histeq_checker (.*);

// ===== test/tb_histogram_equalizer_top.sv =====
// Testbench for the two-pass histogram equalizer: self-predicting, random idling.
`timescale 1ns / 1ps
module tb_histogram_equalizer_top;
  import histeq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [PIX_W-1:0] pixel = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic last_out;

  histogram_equalizer_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pixel(pixel), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_out(pixel_out), .last_out(last_out)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             tail;
  } mapped_t;

  // predictor state
  int unsigned hist[LEVELS];
  int unsigned pix_count;
  logic [PIX_W-1:0] lut[LEVELS];

  mapped_t mapped_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_seen);
  endtask

  function automatic void rebuild_lut();
    longint unsigned cum;
    longint unsigned q;
    cum = 0;
    for (int v = 0; v < LEVELS; v++) begin
      cum += hist[v];
      if (pix_count == 0) q = 0;
      else begin
        q = (255 * cum) / pix_count;
        if (q > 255) q = 255;
      end
      lut[v] = q[PIX_W-1:0];
    end
  endfunction

  function automatic void clear_hist();
    for (int v = 0; v < LEVELS; v++) hist[v] = 0;
    pix_count = 0;
  endfunction

  function automatic void predict(input op_t o, input logic [PIX_W-1:0] p,
                                  input logic l);
    int b;
    b = (int'(p) >= LEVELS) ? LEVELS - 1 : int'(p);
    if (o == OP_COUNT) begin
      if (hist[b] < MAX_PIXELS) hist[b]++;
      if (pix_count < MAX_PIXELS) pix_count++;
      if (l) rebuild_lut();
    end else begin
      mapped_q.push_back('{value: lut[b], tail: l});
      if (l) clear_hist();
    end
  endfunction

  // called at a falling edge; valid stays up after the item until the next
  // call drives a new item or idles
  task automatic send_pixel(input op_t o, input logic [PIX_W-1:0] p, input logic l);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    pixel <= p;
    last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(o, p, l);
    items_sent++;
    @(negedge clk);
  endtask

  // receiver side: random stall, sample at rising edge
  always @(negedge clk) begin
    if (!rst) out_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk) begin
    mapped_t want;
    if (!rst && out_valid && out_ready) begin
      if (mapped_q.size() == 0) begin
        report("unexpected result", pixel_out, -1);
      end else begin
        want = mapped_q.pop_front();
        if (pixel_out !== want.value) report("pixel_out", pixel_out, want.value);
        if (last_out !== want.tail) report("last_out", last_out, want.tail);
      end
      results_seen++;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // one frame: count pass of n pixels then a map pass of m pixels
  task automatic run_frame(input int n, input int m, input bit skewed);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom_range(255, 0));
    for (int i = 0; i < n; i++)
      send_pixel(OP_COUNT, skewed ? base + PIX_W'($urandom_range(7, 0))
                                  : PIX_W'($urandom_range(255, 0)), i == n - 1);
    for (int i = 0; i < m; i++)
      send_pixel(OP_MAP, PIX_W'($urandom_range(255, 0)), i == m - 1);
  endtask

  task automatic test_directed();
    // extremes: an all-zero single-pixel frame, then a frame of max and zero pixels
    send_pixel(OP_COUNT, 8'd0, 1'b1);
    send_pixel(OP_MAP, 8'd0, 1'b0);
    send_pixel(OP_MAP, 8'd255, 1'b1);
    send_pixel(OP_COUNT, 8'd255, 1'b0);
    send_pixel(OP_COUNT, 8'd255, 1'b0);
    send_pixel(OP_COUNT, 8'd0, 1'b1);
    send_pixel(OP_MAP, 8'd0, 1'b0);
    send_pixel(OP_MAP, 8'd254, 1'b0);
    send_pixel(OP_MAP, 8'd255, 1'b1);
    // repeated count pass rebuilds from the accumulated histogram
    send_pixel(OP_COUNT, 8'haa, 1'b1);
    send_pixel(OP_COUNT, 8'h55, 1'b1);
    send_pixel(OP_MAP, 8'haa, 1'b0);
    send_pixel(OP_MAP, 8'h55, 1'b0);
    send_pixel(OP_MAP, 8'h80, 1'b1);
    // table kept after a map pass ends: map again with no count
    send_pixel(OP_MAP, 8'h55, 1'b1);
    send_pixel(OP_MAP, 8'h01, 1'b1);
    drain();
  endtask

  task automatic test_random(input int frames);
    for (int f = 0; f < frames; f++)
      run_frame($urandom_range(12, 1), $urandom_range(10, 1), $urandom_range(1, 0));
    drain();
  endtask

  initial begin
    clear_hist();
    for (int v = 0; v < LEVELS; v++) lut[v] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 34; recv_idle_pct = 65;
    test_random(11);
    send_idle_pct = 65; recv_idle_pct = 34;
    test_random(11);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(11);
    $display("Ran %0d pixels over directed and random frames; %0d mapped results checked.",
             items_sent, results_seen);
    if (errors == 0) $display("tb_histogram_equalizer_top: PASS");
    else $display("tb_histogram_equalizer_top: FAIL");
    $finish;
  end

  // ~37 frame builds expected over the run
  initial begin
    #20_000_000;
    $display("tb_histogram_equalizer_top: FAIL");
    $finish;
  end
endmodule
